// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked by i_clk, off during reset
`define SOM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked by i_clk, off during reset
`define SOM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/som_pkg.sv =====
// types and constants of the segment offset map
package som_pkg;

    localparam int SEG_W  = 32;
    localparam int LEN_W  = 36;
    localparam int VAL_W  = 33;
    localparam int PH_W   = 2;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 72;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_ADD    = 3'd1,
        OP_FINAL  = 3'd2,
        OP_POS2OFF = 3'd3,
        OP_OFF2POS = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FINAL = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        RES_OK,
        RES_FULL,
        RES_NOT_FINAL,
        RES_QUERY
    } t_res;

    typedef struct packed {
        logic [SEG_W-1:0] seg_start;
        logic [SEG_W-1:0] seg_end;
        logic [PH_W-1:0]  seg_phase;
    } t_seg;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic clear;
        logic add;
        logic fin_begin;
        logic key_ld;
        logic cmp_rd;
        logic shift;
        logic place;
        logic len_begin;
        logic len_ev;
        logic fin_done;
        logic q_begin;
        logic q_ev;
        logic res_ld;
        t_res res;
        logic out_ld;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_opcode op;
        logic    full;
        logic    finalized;
        logic    i_lt_n;
        logic    j_zero;
        logic    precedes;
        logic    hit;
        logic    out_free;
    } t_sts;

endpackage

// ===== hw/rtl/som_ram.sv =====
// generic single-port-write ram with registered read
module som_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] i_wa,
    input  logic [W-1:0]                   i_wd,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] i_ra,
    output logic [W-1:0]                   o_rd
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_rd <= r_mem[i_ra];
    end
endmodule

// ===== hw/rtl/som_ctrl.sv =====
// sequencer for clear, add, finalize (insertion sort, length sums) and query scan
module som_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  som_pkg::t_sts  i_sts,
    output som_pkg::t_cmd  o_cmd
);
    import som_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_KEY_CHK, S_KEY_LD, S_J_CHK, S_CMP,
        S_LEN_CHK, S_LEN_EV, S_Q_CHK, S_Q_EV, S_DONE
    } t_state;

    t_state r_state, n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        o_cmd.res = RES_OK;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.res_ld = 1'b1;
                n_state = S_DONE;
                case (i_sts.op)
                    OP_CLEAR: o_cmd.clear = 1'b1;
                    OP_ADD: begin
                        if (i_sts.full) begin
                            o_cmd.res = RES_FULL;
                        end else begin
                            o_cmd.add = 1'b1;
                        end
                    end
                    OP_FINAL: begin
                        o_cmd.res_ld = 1'b0;
                        o_cmd.fin_begin = 1'b1;
                        n_state = S_KEY_CHK;
                    end
                    OP_POS2OFF, OP_OFF2POS: begin
                        if (!i_sts.finalized) begin
                            o_cmd.res = RES_NOT_FINAL;
                        end else begin
                            o_cmd.res_ld = 1'b0;
                            o_cmd.q_begin = 1'b1;
                            n_state = S_Q_CHK;
                        end
                    end
                    default: o_cmd.res = RES_OK;
                endcase
            end
            // ram read at index i is issued in every state, except S_J_CHK with j nonzero, which reads j-1
            S_KEY_CHK: begin
                if (i_sts.i_lt_n) begin
                    n_state = S_KEY_LD;
                end else begin
                    o_cmd.len_begin = 1'b1;
                    n_state = S_LEN_CHK;
                end
            end
            S_KEY_LD: begin
                o_cmd.key_ld = 1'b1;
                n_state = S_J_CHK;
            end
            S_J_CHK: begin
                if (i_sts.j_zero) begin
                    o_cmd.place = 1'b1;
                    n_state = S_KEY_CHK;
                end else begin
                    o_cmd.cmp_rd = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.precedes) begin
                    o_cmd.shift = 1'b1;
                    n_state = S_J_CHK;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state = S_KEY_CHK;
                end
            end
            S_LEN_CHK: begin
                if (i_sts.i_lt_n) begin
                    n_state = S_LEN_EV;
                end else begin
                    o_cmd.fin_done = 1'b1;
                    o_cmd.res_ld = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_LEN_EV: begin
                o_cmd.len_ev = 1'b1;
                n_state = S_LEN_CHK;
            end
            S_Q_CHK: begin
                if (i_sts.i_lt_n && !i_sts.hit) begin
                    n_state = S_Q_EV;
                end else begin
                    o_cmd.res_ld = 1'b1;
                    o_cmd.res = RES_QUERY;
                    n_state = S_DONE;
                end
            end
            S_Q_EV: begin
                o_cmd.q_ev = 1'b1;
                n_state = S_Q_CHK;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== hw/rtl/som_dp.sv =====
// segment tables, counters, compare/translate logic and output register
module som_dp #(
    parameter int MAX_SEGMENTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic                              i_cfg_wr_data,
    input  logic [som_pkg::IN_TDATA_W-1:0]    i_tdata,
    input  logic [2:0]                        i_tuser,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [som_pkg::OUT_TDATA_W-1:0]   o_tdata,
    output logic [1:0]                        o_tuser,
    input  som_pkg::t_cmd                     i_cmd,
    output som_pkg::t_sts                     o_sts
);
    import som_pkg::*;

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

    t_opcode          r_op;
    t_seg             r_item;
    logic [SEG_W-1:0] r_q;
    logic [CW-1:0]    r_count, r_i, r_j;
    logic             r_fin, r_minus, r_hit, r_valid;
    t_seg             r_key;
    logic [LEN_W-1:0] r_run, r_total;
    logic [PH_W-1:0]  r_fphase;
    logic [SEG_W-1:0] r_map;
    t_res             r_res;
    logic [1:0]       r_ostatus;
    logic [VAL_W-1:0] r_omapped;
    logic [LEN_W-1:0] r_ototal;
    logic [PH_W-1:0]  r_ophase;

    t_seg             seg_rd, seg_wd;
    logic [AW-1:0]    seg_wa, seg_ra;
    logic             seg_we;
    logic [LEN_W-1:0] lb_rd;
    logic [SEG_W:0]   seg_len;
    logic [LEN_W:0]   run_sum, lo_plus_len;
    logic [SEG_W-1:0] q_dist, off;
    logic [LEN_W:0]   pos_sum;
    logic             q_hit;
    logic [SEG_W-1:0] q_map;

    assign seg_we = i_cmd.add | i_cmd.shift | i_cmd.place;
    assign seg_wa = i_cmd.add ? r_count[AW-1:0] : r_j[AW-1:0];
    assign seg_wd = i_cmd.add ? r_item : (i_cmd.shift ? seg_rd : r_key);
    assign seg_ra = i_cmd.cmp_rd ? AW'(r_j - 1'b1) : r_i[AW-1:0];

    som_ram #(.W($bits(t_seg)), .D(MAX_SEGMENTS)) u_seg_ram (
        .i_clk (i_clk),
        .i_we  (seg_we),
        .i_wa  (seg_wa),
        .i_wd  (seg_wd),
        .i_ra  (seg_ra),
        .o_rd  (seg_rd)
    );

    som_ram #(.W(LEN_W), .D(MAX_SEGMENTS)) u_len_ram (
        .i_clk (i_clk),
        .i_we  (i_cmd.len_ev),
        .i_wa  (r_i[AW-1:0]),
        .i_wd  (r_run),
        .i_ra  (r_i[AW-1:0]),
        .o_rd  (lb_rd)
    );

    // inclusive length, zero for an inverted segment
    assign seg_len = (seg_rd.seg_end >= seg_rd.seg_start)
                   ? ({1'b0, seg_rd.seg_end} - {1'b0, seg_rd.seg_start} + 1'b1)
                   : '0;
    assign run_sum = {1'b0, r_run} + (LEN_W + 1)'(seg_len);

    always_comb begin
        q_dist = r_minus ? (seg_rd.seg_end - r_q) : (r_q - seg_rd.seg_start);
        pos_sum = {1'b0, lb_rd} + (LEN_W + 1)'(q_dist);
        lo_plus_len = {1'b0, lb_rd} + (LEN_W + 1)'(seg_len);
        off = r_q - lb_rd[SEG_W-1:0];
        if (r_op == OP_POS2OFF) begin
            q_hit = (r_q >= seg_rd.seg_start) && (r_q <= seg_rd.seg_end);
            q_map = (pos_sum > (LEN_W + 1)'(32'hFFFF_FFFF)) ? '1 : pos_sum[SEG_W-1:0];
        end else begin
            q_hit = (seg_len != '0) && ((LEN_W + 1)'(r_q) >= {1'b0, lb_rd})
                  && ((LEN_W + 1)'(r_q) < lo_plus_len);
            q_map = r_minus ? (seg_rd.seg_end - off) : (seg_rd.seg_start + off);
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.full      = (r_count == MAX_CNT);
    assign o_sts.finalized = r_fin;
    assign o_sts.i_lt_n    = (r_i < r_count);
    assign o_sts.j_zero    = (r_j == '0);
    assign o_sts.precedes  = r_minus ? (r_key.seg_start > seg_rd.seg_start)
                                     : (r_key.seg_start < seg_rd.seg_start);
    assign o_sts.hit       = r_hit;
    assign o_sts.out_free  = !r_valid || i_out_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fin   <= 1'b0;
            r_minus <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_minus <= i_cfg_wr_data;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_fin   <= 1'b0;
            end
            if (i_cmd.add) begin
                r_count <= r_count + 1'b1;
                r_fin   <= 1'b0;
            end
            if (i_cmd.fin_done) begin
                r_fin <= 1'b1;
            end
            if (i_cmd.out_ld) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_opcode'(i_tuser);
            r_item <= '{seg_start: i_tdata[31:0], seg_end: i_tdata[63:32],
                        seg_phase: i_tdata[65:64]};
            r_q    <= i_tdata[97:66];
        end
        if (i_cmd.fin_begin) begin
            r_i <= CW'(1);
        end
        if (i_cmd.key_ld) begin
            r_key <= seg_rd;
            r_j   <= r_i;
        end
        if (i_cmd.shift) begin
            r_j <= r_j - 1'b1;
        end
        if (i_cmd.place) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.len_begin) begin
            r_i      <= '0;
            r_run    <= '0;
            r_fphase <= '0;
        end
        if (i_cmd.len_ev) begin
            r_run <= run_sum[LEN_W] ? '1 : run_sum[LEN_W-1:0];
            if (r_i == '0) begin
                r_fphase <= seg_rd.seg_phase;
            end
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.fin_done) begin
            r_total <= r_run;
        end
        if (i_cmd.q_begin) begin
            r_i   <= '0;
            r_hit <= 1'b0;
        end
        if (i_cmd.q_ev) begin
            r_hit <= q_hit;
            r_map <= q_map;
            r_i   <= r_i + 1'b1;
        end
        if (i_cmd.res_ld) begin
            r_res <= i_cmd.res;
        end
        if (i_cmd.out_ld) begin
            case (r_res)
                RES_FULL: begin
                    r_ostatus <= ST_FULL;
                    r_omapped <= '0;
                    r_ototal  <= '0;
                    r_ophase  <= '0;
                end
                RES_NOT_FINAL: begin
                    r_ostatus <= ST_NOT_FINAL;
                    r_omapped <= '0;
                    r_ototal  <= '0;
                    r_ophase  <= '0;
                end
                RES_QUERY: begin
                    r_ostatus <= r_hit ? ST_OK : ST_NOT_FOUND;
                    r_omapped <= r_hit ? {1'b0, r_map} : '1;
                    r_ototal  <= r_total;
                    r_ophase  <= r_fphase;
                end
                default: begin
                    r_ostatus <= ST_OK;
                    r_omapped <= '0;
                    r_ototal  <= '0;
                    r_ophase  <= '0;
                end
            endcase
        end
    end

    assign o_out_valid = r_valid;
    assign o_tuser     = r_ostatus;
    assign o_tdata     = {1'b0, r_ophase, r_ototal, r_omapped};
endmodule

// ===== hw/rtl/segment_offset_map_unit.sv =====
// segment offset map: top level joining controller and datapath
// Holds up to MAX_SEGMENTS inclusive segments and translates positions to
// concatenated offsets and back, one command at a time. Clear, add and
// rejected commands pass from dispatch to the done state for their result.
// Finalize runs an insertion sort through the segment ram, shifting one
// element per move, then sums the running lengths segment by segment. A
// query scans the sorted table segment by segment until the first hit or
// the end of the table. The next command is taken once a result sits in
// the output register.
module segment_offset_map_unit #(
    parameter int MAX_SEGMENTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_wr_data,   // strand_minus
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,    // seg_start, seg_end, seg_phase, query_value, pad
    input  logic [2:0]   s_axis_tuser,    // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,    // mapped_value, total_length, first_phase, pad
    output logic [1:0]   m_axis_tuser     // status
);
    import som_pkg::*;

    t_cmd cmd;
    t_sts sts;

    som_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    som_dp #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_tdata       (s_axis_tdata),
        .i_tuser       (s_axis_tuser),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_tdata       (m_axis_tdata),
        .o_tuser       (m_axis_tuser),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );
endmodule

// ===== hw/rtl/som_checker.sv =====
// port-level checks of the segment offset map, bound to the top level
`include "assert_macros.svh"

module som_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [71:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    import som_pkg::*;

    `SOM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
    `SOM_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second command taken while busy")
    `SOM_ASSERT_NOW(a_miss_value, m_axis_tvalid && (m_axis_tuser == ST_NOT_FOUND), m_axis_tdata[32:0] == '1, "miss without -1")
    `SOM_ASSERT_NOW(a_err_zero, m_axis_tvalid && (m_axis_tuser == ST_FULL || m_axis_tuser == ST_NOT_FINAL), m_axis_tdata == '0, "error result carries data")
endmodule

bind segment_offset_map_unit som_checker u_som_checker (.*);
